// ===== src/bmhpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhpq_pkg: shared types and constants for the heap priority queue
// Depth, field widths, command and status codes, heap entry layout, the
// sequencer states and the memory request bundle.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int NUM_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CHILD_W     = IDX_W + 2;

  localparam int PRIO_W  = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;

  localparam logic [DATA_W-1:0] EMPTY_DATA = 32'hFFFF_FAC7;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_SERVICE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic        [DATA_W-1:0] data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_PICK,
    S_DN_CMP,
    S_RESP
  } state_t;

endpackage

// ===== src/bmhpq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhpq_if: command and response channels of the heap priority queue
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bmhpq_cmd_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     command;
  logic signed [bmhpq_pkg::PRIO_W-1:0]      priority_req;
  logic signed [bmhpq_pkg::DATA_W-1:0]      payload;

  modport source (output valid, command, priority_req, payload, input ready);
  modport sink   (input valid, command, priority_req, payload, output ready);
endinterface

interface bmhpq_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     status;
  logic                                     front_valid;
  logic signed [bmhpq_pkg::DATA_W-1:0]      front_data;
  logic        [bmhpq_pkg::COUNT_W-1:0]     count;

  modport source (output valid, status, front_valid, front_data, count, input ready);
  modport sink   (input valid, status, front_valid, front_data, count, output ready);
endinterface

// ===== src/bmhpq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhpq_ram: simple dual-port RAM holding the heap entries
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bmhpq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bmhpq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhpq_ctrl: sift sequencer with one shared priority comparator
// Walks the heap one level at a time, moving entries through the RAM, and
// holds the response in an output register.
// ----------------------------------------------------------------------------
module bmhpq_ctrl (
  input  logic                clk,
  input  logic                rst,
  bmhpq_cmd_if.sink           cmd,
  bmhpq_rsp_if.source         rsp,
  output bmhpq_pkg::mem_req_t mem_req,
  input  bmhpq_pkg::entry_t   rdata
);
  import bmhpq_pkg::*;

  state_t state, state_next;

  logic [NUM_W-1:0] n;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] cand_idx;
  entry_t           moving;
  entry_t           cand;
  logic             fail;
  logic [DATA_W-1:0] root_data;

  logic               res_valid;
  logic               res_status;
  logic               res_front_valid;
  logic [DATA_W-1:0]  res_front_data;
  logic [COUNT_W-1:0] res_count;

  logic [IDX_W-1:0]   parent_idx;
  logic [IDX_W-1:0]   last_idx;
  logic [CHILD_W-1:0] left_w;
  logic [CHILD_W-1:0] right_w;
  logic               left_in;
  logic               right_in;
  logic               full;
  logic               accept;
  logic               load_res;

  logic signed [PRIO_W-1:0] cmp_a;
  logic signed [PRIO_W-1:0] cmp_b;
  logic                     cmp_gt;

  assign parent_idx = IDX_W'((pos - IDX_W'(1)) >> 1);
  assign last_idx   = IDX_W'(n - NUM_W'(1));
  assign left_w     = CHILD_W'({pos, 1'b1});
  assign right_w    = left_w + CHILD_W'(1);
  assign left_in    = left_w < CHILD_W'(n);
  assign right_in   = right_w < CHILD_W'(n);
  assign full       = n == NUM_W'(QUEUE_DEPTH);
  assign accept     = cmd.valid && cmd.ready;
  assign load_res   = (state == S_RESP) && (!res_valid || rsp.ready);

  assign cmd.ready = state == S_IDLE;

  // shared comparator
  always_comb begin
    unique case (state)
      S_DN_PICK: begin
        cmp_a = cand.prio;
        cmp_b = rdata.prio;
      end
      S_DN_CMP: begin
        cmp_a = cand.prio;
        cmp_b = moving.prio;
      end
      default: begin
        cmp_a = moving.prio;
        cmp_b = rdata.prio;
      end
    endcase
  end

  assign cmp_gt = cmp_a > cmp_b;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          if (cmd.command == CMD_INSERT) begin
            state_next = full ? S_RESP : S_UP_RD;
          end else begin
            state_next = (n == '0) ? S_RESP : S_DN_LAST;
          end
        end
      end
      S_UP_RD:   state_next = (pos == '0) ? S_RESP : S_UP_CMP;
      S_UP_CMP:  state_next = cmp_gt ? S_UP_RD : S_RESP;
      S_DN_LAST: state_next = (n == '0) ? S_RESP : S_DN_RDL;
      S_DN_RDL:  state_next = left_in ? S_DN_RDR : S_RESP;
      S_DN_RDR:  state_next = right_in ? S_DN_PICK : S_DN_CMP;
      S_DN_PICK: state_next = S_DN_CMP;
      S_DN_CMP:  state_next = cmp_gt ? S_DN_RDL : S_RESP;
      S_RESP: begin
        if (!res_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = pos;
    mem_req.wdata = moving;
    mem_req.raddr = last_idx;
    unique case (state)
      S_IDLE:    mem_req.raddr = last_idx;
      S_UP_RD: begin
        mem_req.raddr = parent_idx;
        mem_req.we    = pos == '0;
      end
      S_UP_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = cmp_gt ? rdata : moving;
      end
      S_DN_RDL: begin
        mem_req.raddr = left_w[IDX_W-1:0];
        mem_req.we    = !left_in;
      end
      S_DN_RDR:  mem_req.raddr = right_w[IDX_W-1:0];
      S_DN_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = cmp_gt ? cand : moving;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (cmd.command == CMD_INSERT) begin
          if (!full) begin
            n <= n + NUM_W'(1);
          end
        end else if (n != '0) begin
          n <= n - NUM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      moving.prio <= cmd.priority_req;
      moving.data <= cmd.payload;
      pos         <= IDX_W'(n);
      fail        <= (cmd.command == CMD_INSERT) ? full : (n == '0);
    end
    if (mem_req.we && (mem_req.waddr == '0)) begin
      root_data <= mem_req.wdata.data;
    end
    unique case (state)
      S_UP_CMP: begin
        if (cmp_gt) begin
          pos <= parent_idx;
        end
      end
      S_DN_LAST: begin
        moving <= rdata;
        pos    <= '0;
      end
      S_DN_RDR: begin
        cand     <= rdata;
        cand_idx <= left_w[IDX_W-1:0];
      end
      S_DN_PICK: begin
        if (!cmp_gt) begin
          cand     <= rdata;
          cand_idx <= right_w[IDX_W-1:0];
        end
      end
      S_DN_CMP: begin
        if (cmp_gt) begin
          pos <= cand_idx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_status      <= fail;
      res_front_valid <= n != '0;
      res_front_data  <= (n != '0) ? root_data : EMPTY_DATA;
      res_count       <= COUNT_W'(n);
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.status      = res_status;
  assign rsp.front_valid = res_front_valid;
  assign rsp.front_data  = res_front_data;
  assign rsp.count       = res_count;

endmodule

// ===== src/binary_max_heap_priority_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_core: max-priority queue on a binary heap
// Each command beat on cmd inserts a (priority, payload) pair or services
// the highest-priority entry; exactly one response beat follows on rsp with
// a status (failure on insert when full, on service when empty), whether
// the queue holds entries, the payload at the root (-1337 when empty) and
// the entry count. Equal priorities never swap.
// The heap lives in a one-write, one-read RAM with registered read data,
// and one sequencer walks it level by level with a single comparator.
// Insert climbs from the new leaf towards the root, reading the parent
// and writing back one level per step; service moves the last entry to
// the root and descends, where each level costs two RAM reads (left and
// right child) and the compare/write-back.
// cmd.ready is high only while idle.
// The response sits in an output register, so the next command is taken
// while it waits; a stalled rsp holds the block before its next response.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_core (
  input logic         clk,
  input logic         rst,
  bmhpq_cmd_if.sink   cmd,
  bmhpq_rsp_if.source rsp
);
  import bmhpq_pkg::*;

  mem_req_t mem_req;
  entry_t   rdata;

  bmhpq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rsp     (rsp),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  bmhpq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("command taken while a command is in flight");

  a_front_matches_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.front_valid == (rsp.count != '0)))
    else $error("front_valid disagrees with count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (32'(rsp.count) <= 32'(QUEUE_DEPTH)))
    else $error("count beyond queue depth");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> !cmd.ready)
    else $error("heap written while idle");

endmodule
